// ----- rtl/alie_pkg.sv -----
// Package for the average loss interval estimator.
// Holds the sequencer state type, register and command codes, the weight table
// and the control/status structs shared with the serial divider.
`default_nettype none

package alie_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RECORD,
    ST_WALK,
    ST_MUL_A,
    ST_MUL_B,
    ST_DIV_AVG,
    ST_WAIT_AVG,
    ST_DIV_RATE,
    ST_WAIT_RATE,
    ST_DONE
  } state_t;

  localparam logic CMD_UPDATE  = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  localparam logic [1:0] REG_FIRST_LOSS_CAP = 2'd0;
  localparam logic [1:0] REG_INTERVAL_MIN   = 2'd1;
  localparam logic [1:0] REG_INTERVAL_MAX   = 2'd2;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int IVAL_W  = 5;
  localparam int DEN_W   = 5;
  localparam int WT_W    = 3;
  localparam int K_W     = 3;

  localparam logic [IVAL_W-1:0] FIRST_LOSS_CAP_RST = 5'd10;
  localparam logic [IVAL_W-1:0] INTERVAL_MIN_RST   = 5'd2;
  localparam logic [IVAL_W-1:0] INTERVAL_MAX_RST   = 5'd20;
  localparam logic [IVAL_W-1:0] NO_RX_INTERVAL     = 5'd2;

  // Quotient widths of the two divisions and the divider step counter
  localparam int AVG_QBITS  = 24;
  localparam int RATE_QBITS = 16;
  localparam int CNT_W      = 5;
  localparam int FRAC_BITS  = 8;

  typedef struct packed {
    logic start;
    logic rate_mode;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } div_sts_t;

  // Interval weights in fifths, newest first
  function automatic logic [WT_W-1:0] weight_fifths(input logic [K_W-1:0] idx);
    logic [WT_W-1:0] w;
    case (idx)
      3'd0: w = 3'd5;
      3'd1: w = 3'd5;
      3'd2: w = 3'd5;
      3'd3: w = 3'd5;
      3'd4: w = 3'd4;
      3'd5: w = 3'd3;
      3'd6: w = 3'd2;
      default: w = 3'd1;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/alie_div.sv -----
// Restoring serial divider, one quotient bit per cycle, with up-front overflow check.
// Produces a 24- or 16-bit quotient; depends on alie_pkg for control/status types.
`default_nettype none

module alie_div #(
  parameter int DW = 27,
  parameter int VW = 19
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire alie_pkg::div_ctl_t                 ctl,
  input  wire logic [DW-1:0]                      dividend,
  input  wire logic [VW-1:0]                      divisor,
  output alie_pkg::div_sts_t                      sts,
  output logic      [alie_pkg::AVG_QBITS-1:0]     quotient
);

  logic                               busy;
  logic                               done;
  logic                               ovf;
  logic [alie_pkg::CNT_W-1:0]         cnt;
  logic [VW-1:0]                      rem;
  logic [alie_pkg::AVG_QBITS-1:0]     low;

  logic [DW-1:0]                      hi;
  logic                               hi_ovf;
  logic [VW:0]                        trial;
  logic                               ge;

  always_comb begin
    // Part of the dividend above the quotient bits
    if (ctl.rate_mode) begin
      hi = DW'(dividend >> alie_pkg::RATE_QBITS);
    end else begin
      hi = DW'(dividend >> alie_pkg::AVG_QBITS);
    end
    hi_ovf = hi >= DW'(divisor);
    trial  = {rem, low[alie_pkg::AVG_QBITS-1]};
    ge     = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        if (hi_ovf) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= ctl.rate_mode ? alie_pkg::CNT_W'(alie_pkg::RATE_QBITS)
                                : alie_pkg::CNT_W'(alie_pkg::AVG_QBITS);
        end
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == alie_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      ovf      <= hi_ovf;
      quotient <= '0;
      rem      <= hi[VW-1:0];
      if (ctl.rate_mode) begin
        low <= {dividend[alie_pkg::RATE_QBITS-1:0],
                {(alie_pkg::AVG_QBITS-alie_pkg::RATE_QBITS){1'b0}}};
      end else begin
        low <= dividend[alie_pkg::AVG_QBITS-1:0];
      end
    end else if (busy) begin
      quotient <= {quotient[alie_pkg::AVG_QBITS-2:0], ge};
      low      <= {low[alie_pkg::AVG_QBITS-2:0], 1'b0};
      if (ge) begin
        rem <= VW'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[VW-1:0];
      end
    end
  end

  assign sts = {busy, done, ovf};

endmodule

`default_nettype wire

// ----- rtl/average_loss_interval_estimator_unit.sv -----
// Top level of the average loss interval estimator: APB registers, loss
// recording ring, sequencer and weighted-average datapath. Uses alie_pkg and alie_div.
`default_nettype none

// One item is taken at a time; item_stall stays high from the transfer until
// the result is loaded into the output register. A packet update has a record
// step, a walk of the ring with a multiply-add per interval held (1 to
// HISTORY_DEPTH), the MUL_A and MUL_B steps through the shared multiplier for
// the cross-compare of the two averages (only when more than one interval is
// held), then the serial divider runs 24 steps for the average interval and
// 16 for the loss rate unless the average is zero. A saturating quotient skips its
// division steps. A restart, or an update with no history, skips to the done state.
// The result register lets a finished result wait while the next item is taken.

module average_loss_interval_estimator_unit #(
  parameter int HISTORY_DEPTH = 8,
  parameter int SEQ_BITS      = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [alie_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [alie_pkg::PDATA_W-1:0]  pwdata,
  output logic      [alie_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic                          cmd,
  input  wire logic [SEQ_BITS-1:0]           seq_number,
  input  wire logic [SEQ_BITS-1:0]           last_received,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic      [15:0]                   loss_rate,
  output logic      [23:0]                   avg_interval,
  output logic                               estimate_valid
);

  localparam int HEAD_W = $clog2(HISTORY_DEPTH);
  localparam int LEN_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int NUM_W  = SEQ_BITS + 3;
  localparam int DIV_W  = (NUM_W + 8 > 25) ? NUM_W + 8 : 25;
  localparam int PROD_W = NUM_W + alie_pkg::DEN_W;

  // Configuration registers
  logic [alie_pkg::IVAL_W-1:0] first_loss_cap;
  logic [alie_pkg::IVAL_W-1:0] interval_min;
  logic [alie_pkg::IVAL_W-1:0] interval_max;
  logic                        cfg_wr;
  logic [1:0]                  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_loss_cap <= alie_pkg::FIRST_LOSS_CAP_RST;
      interval_min   <= alie_pkg::INTERVAL_MIN_RST;
      interval_max   <= alie_pkg::INTERVAL_MAX_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        alie_pkg::REG_FIRST_LOSS_CAP: first_loss_cap <= pwdata[alie_pkg::IVAL_W-1:0];
        alie_pkg::REG_INTERVAL_MIN:   interval_min   <= pwdata[alie_pkg::IVAL_W-1:0];
        alie_pkg::REG_INTERVAL_MAX:   interval_max   <= pwdata[alie_pkg::IVAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      alie_pkg::REG_FIRST_LOSS_CAP: prdata = alie_pkg::PDATA_W'(first_loss_cap);
      alie_pkg::REG_INTERVAL_MIN:   prdata = alie_pkg::PDATA_W'(interval_min);
      alie_pkg::REG_INTERVAL_MAX:   prdata = alie_pkg::PDATA_W'(interval_max);
      default:                      prdata = '0;
    endcase
  end

  // Sequencer and datapath state
  alie_pkg::state_t state;
  alie_pkg::state_t state_next;

  logic                        cmd_r;
  logic [SEQ_BITS-1:0]         seq_r;
  logic [SEQ_BITS-1:0]         last_r;

  logic [alie_pkg::IVAL_W-1:0] ring [HISTORY_DEPTH];
  logic [HEAD_W-1:0]           ring_head;
  logic [LEN_W-1:0]            ring_length;
  logic [SEQ_BITS-1:0]         last_loss_seq;
  logic [15:0]                 held_loss_rate;
  logic [23:0]                 held_avg_interval;

  logic [HEAD_W-1:0]           slot;
  logic [alie_pkg::K_W-1:0]    k;
  logic [NUM_W-1:0]            num_a;
  logic [NUM_W-1:0]            num_b;
  logic [alie_pkg::DEN_W-1:0]  den_a;
  logic [alie_pkg::DEN_W-1:0]  den_b;
  logic [PROD_W-1:0]           p1;
  logic                        pick_b;

  // Loss recording
  logic [SEQ_BITS-1:0]         gap;
  logic                        loss;
  logic [SEQ_BITS-1:0]         span;
  logic [SEQ_BITS:0]           ival_raw;
  logic [SEQ_BITS:0]           ival_lo;
  logic [alie_pkg::IVAL_W-1:0] ival;
  logic [HEAD_W-1:0]           head_inc;
  logic [LEN_W-1:0]            len_after;
  logic [SEQ_BITS-1:0]         s0;

  always_comb begin
    gap      = seq_r - (last_r + 1'b1);
    loss     = (gap != '0) && !gap[SEQ_BITS-1];
    span     = last_r - last_loss_seq;
    ival_raw = {1'b0, span} + 1'b1;
    ival_lo  = (ival_raw < (SEQ_BITS+1)'(interval_min)) ? (SEQ_BITS+1)'(interval_min)
                                                         : ival_raw;
    if (last_loss_seq == '0) begin
      if (last_r == '0) begin
        ival = alie_pkg::NO_RX_INTERVAL;
      end else if (ival_raw > (SEQ_BITS+1)'(first_loss_cap)) begin
        ival = first_loss_cap;
      end else begin
        ival = ival_raw[alie_pkg::IVAL_W-1:0];
      end
    end else if (ival_lo > (SEQ_BITS+1)'(interval_max)) begin
      ival = interval_max;
    end else begin
      ival = ival_lo[alie_pkg::IVAL_W-1:0];
    end
    head_inc = (ring_head == HEAD_W'(HISTORY_DEPTH - 1)) ? '0 : ring_head + 1'b1;
    if (loss && ring_length != LEN_W'(HISTORY_DEPTH)) begin
      len_after = ring_length + 1'b1;
    end else begin
      len_after = ring_length;
    end
    // Packets since the last loss; one right after a loss is recorded
    s0 = loss ? SEQ_BITS'(1) : seq_r - last_loss_seq;
  end

  // Ring walk
  logic [alie_pkg::IVAL_W-1:0] entry;
  logic [3:0]                  kp1;
  logic [3:0]                  len4;
  logic                        use_b;
  logic                        walk_last;
  logic [alie_pkg::WT_W-1:0]   wa;
  logic [alie_pkg::WT_W-1:0]   wb;
  logic [7:0]                  prod_a;
  logic [7:0]                  prod_b;
  logic [HEAD_W-1:0]           slot_dec;

  always_comb begin
    entry     = ring[slot];
    kp1       = 4'(k) + 4'd1;
    len4      = 4'(ring_length);
    use_b     = kp1 < len4;
    walk_last = kp1 == len4;
    wa        = alie_pkg::weight_fifths(k);
    wb        = alie_pkg::weight_fifths(kp1[alie_pkg::K_W-1:0]);
    prod_a    = 8'(wa) * 8'(entry);
    prod_b    = 8'(wb) * 8'(entry);
    slot_dec  = (slot == '0) ? HEAD_W'(HISTORY_DEPTH - 1) : slot - 1'b1;
  end

  // Shared multiplier for the cross-compare
  logic [NUM_W-1:0]           mul_x;
  logic [alie_pkg::DEN_W-1:0] mul_y;
  logic [PROD_W-1:0]          mul_p;

  assign mul_p = PROD_W'(mul_x) * PROD_W'(mul_y);

  logic [NUM_W-1:0]           num_sel;
  logic [alie_pkg::DEN_W-1:0] den_sel;

  assign num_sel = pick_b ? num_b : num_a;
  assign den_sel = pick_b ? den_b : den_a;

  // Divider
  alie_pkg::div_ctl_t div_ctl;
  alie_pkg::div_sts_t div_sts;
  logic [DIV_W-1:0]   div_dividend;
  logic [NUM_W-1:0]   div_divisor;
  logic [23:0]        div_q;

  always_comb begin
    if (div_ctl.rate_mode) begin
      div_dividend = DIV_W'({den_sel, 16'h0000}) + DIV_W'(num_sel[NUM_W-1:1]);
      div_divisor  = num_sel;
    end else begin
      div_dividend = DIV_W'({num_sel, {alie_pkg::FRAC_BITS{1'b0}}})
                   + DIV_W'(den_sel[alie_pkg::DEN_W-1:1]);
      div_divisor  = NUM_W'(den_sel);
    end
  end

  alie_div #(
    .DW(DIV_W),
    .VW(NUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quotient (div_q)
  );

  // Next state
  logic out_free;

  assign out_free = !result_valid || !result_stall;

  always_comb begin
    state_next = state;
    case (state)
      alie_pkg::ST_IDLE: begin
        if (item_valid) state_next = alie_pkg::ST_RECORD;
      end
      alie_pkg::ST_RECORD: begin
        if (cmd_r == alie_pkg::CMD_RESTART || len_after == '0) begin
          state_next = alie_pkg::ST_DONE;
        end else begin
          state_next = alie_pkg::ST_WALK;
        end
      end
      alie_pkg::ST_WALK: begin
        if (walk_last) begin
          state_next = (len4 > 4'd1) ? alie_pkg::ST_MUL_A : alie_pkg::ST_DIV_AVG;
        end
      end
      alie_pkg::ST_MUL_A:   state_next = alie_pkg::ST_MUL_B;
      alie_pkg::ST_MUL_B:   state_next = alie_pkg::ST_DIV_AVG;
      alie_pkg::ST_DIV_AVG: state_next = alie_pkg::ST_WAIT_AVG;
      alie_pkg::ST_WAIT_AVG: begin
        if (div_sts.done) begin
          state_next = (num_sel == '0) ? alie_pkg::ST_DONE : alie_pkg::ST_DIV_RATE;
        end
      end
      alie_pkg::ST_DIV_RATE: state_next = alie_pkg::ST_WAIT_RATE;
      alie_pkg::ST_WAIT_RATE: begin
        if (div_sts.done) state_next = alie_pkg::ST_DONE;
      end
      alie_pkg::ST_DONE: begin
        if (out_free) state_next = alie_pkg::ST_IDLE;
      end
      default: state_next = alie_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  logic take_item;
  logic do_record;
  logic do_walk;
  logic do_mul_a;
  logic do_mul_b;
  logic avg_done;
  logic rate_done;
  logic load_out;

  always_comb begin
    item_stall        = 1'b1;
    do_record         = 1'b0;
    do_walk           = 1'b0;
    do_mul_a          = 1'b0;
    do_mul_b          = 1'b0;
    avg_done          = 1'b0;
    rate_done         = 1'b0;
    load_out          = 1'b0;
    div_ctl.start     = 1'b0;
    div_ctl.rate_mode = 1'b0;
    mul_x             = num_b;
    mul_y             = den_a;
    case (state)
      alie_pkg::ST_IDLE:   item_stall = 1'b0;
      alie_pkg::ST_RECORD: do_record  = 1'b1;
      alie_pkg::ST_WALK:   do_walk    = 1'b1;
      alie_pkg::ST_MUL_A: begin
        do_mul_a = 1'b1;
        mul_x    = num_a;
        mul_y    = den_b;
      end
      alie_pkg::ST_MUL_B:   do_mul_b = 1'b1;
      alie_pkg::ST_DIV_AVG: div_ctl.start = 1'b1;
      alie_pkg::ST_WAIT_AVG: avg_done = div_sts.done;
      alie_pkg::ST_DIV_RATE: begin
        div_ctl.start     = 1'b1;
        div_ctl.rate_mode = 1'b1;
      end
      alie_pkg::ST_WAIT_RATE: begin
        div_ctl.rate_mode = 1'b1;
        rate_done         = div_sts.done;
      end
      alie_pkg::ST_DONE: load_out = out_free;
      default: ;
    endcase
  end

  assign take_item = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= alie_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_head         <= HEAD_W'(HISTORY_DEPTH - 1);
      ring_length       <= '0;
      last_loss_seq     <= '0;
      held_loss_rate    <= '0;
      held_avg_interval <= '0;
      result_valid      <= 1'b0;
    end else begin
      if (do_record) begin
        if (cmd_r == alie_pkg::CMD_RESTART) begin
          ring_length       <= '0;
          held_loss_rate    <= '0;
          held_avg_interval <= '0;
        end else if (loss) begin
          ring_head     <= head_inc;
          ring_length   <= len_after;
          last_loss_seq <= seq_r - 1'b1;
        end
      end
      if (avg_done) begin
        held_avg_interval <= div_sts.ovf ? 24'hFFFFFF : div_q;
        // Zero average: the rate saturates
        if (num_sel == '0) held_loss_rate <= 16'hFFFF;
      end
      if (rate_done) begin
        held_loss_rate <= div_sts.ovf ? 16'hFFFF : div_q[15:0];
      end
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (take_item) begin
      cmd_r  <= cmd;
      seq_r  <= seq_number;
      last_r <= last_received;
    end
    if (do_record && cmd_r == alie_pkg::CMD_UPDATE && loss) begin
      ring[head_inc] <= ival;
    end
    if (do_record) begin
      slot   <= loss ? head_inc : ring_head;
      k      <= '0;
      num_a  <= '0;
      den_a  <= '0;
      num_b  <= NUM_W'({s0, 2'b00}) + NUM_W'(s0);
      den_b  <= alie_pkg::DEN_W'(alie_pkg::weight_fifths('0));
      pick_b <= 1'b0;
    end
    if (do_walk) begin
      slot  <= slot_dec;
      k     <= k + 1'b1;
      num_a <= num_a + NUM_W'(prod_a);
      den_a <= den_a + alie_pkg::DEN_W'(wa);
      if (use_b) begin
        num_b <= num_b + NUM_W'(prod_b);
        den_b <= den_b + alie_pkg::DEN_W'(wb);
      end
    end
    if (do_mul_a) begin
      p1 <= mul_p;
    end
    if (do_mul_b) begin
      pick_b <= p1 < mul_p;
    end
    if (load_out) begin
      loss_rate      <= held_loss_rate;
      avg_interval   <= held_avg_interval;
      estimate_valid <= ring_length != '0;
    end
  end

  // Checks
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    ring_length <= LEN_W'(HISTORY_DEPTH))
    else $error("ring length beyond history depth");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_ctl.start |-> !div_sts.busy)
    else $error("divider started while busy");

  a_take_record: assert property (@(posedge clk) disable iff (rst)
    take_item |=> state == alie_pkg::ST_RECORD)
    else $error("transfer did not start recording");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == alie_pkg::ST_DONE && !result_stall) |=> result_valid)
    else $error("finished result not loaded");

endmodule

`default_nettype wire

// ----- tb/loss_estimate_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the average loss interval estimator: snoops the APB writes
// and both item channels, predicts each estimate and compares it. Uses alie_pkg.

module loss_estimate_checker (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic                                     pready,
  input  logic [alie_pkg::PADDR_W-1:0]             paddr,
  input  logic [alie_pkg::PDATA_W-1:0]             pwdata,
  input  logic                                     item_valid,
  input  logic                                     item_stall,
  input  logic                                     cmd,
  input  logic [15:0]                              seq_number,
  input  logic [15:0]                              last_received,
  input  logic                                     result_valid,
  input  logic                                     result_stall,
  input  logic [15:0]                              loss_rate,
  input  logic [23:0]                              avg_interval,
  input  logic                                     estimate_valid,
  output int                                       fail_count,
  output int                                       outstanding,
  output int                                       checked_count,
  output int                                       loss_count
);

  typedef struct packed {
    logic [15:0] rate;
    logic [23:0] avg;
    logic        valid;
  } estimate_t;

  // Weights in fifths, newest interval in the low bits
  localparam logic [23:0] FIFTHS = {3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5};

  estimate_t   expected_q[$];
  logic [4:0]  cap_cfg, min_cfg, max_cfg;
  logic [4:0]  hist_ring [8];
  logic [2:0]  hist_head;
  int          hist_len;
  logic [15:0] loss_mark;
  logic [15:0] held_rate;
  logic [23:0] held_avg;
  int          errors = 0;
  int          checked = 0;
  int          losses = 0;

  initial begin
    fail_count = 0;
    outstanding = 0;
    checked_count = 0;
    loss_count = 0;
  end

  task automatic record_interval(input logic [15:0] seq, input logic [15:0] last);
    logic [15:0] diff;
    logic [16:0] ival;
    diff = last - loss_mark;
    ival = diff + 17'd1;
    if (loss_mark == 16'd0) begin
      if (last == 16'd0) ival = 17'd2;
      else if (ival > 17'(cap_cfg)) ival = 17'(cap_cfg);
    end else begin
      // max wins when the clamps cross
      if (ival < 17'(min_cfg)) ival = 17'(min_cfg);
      if (ival > 17'(max_cfg)) ival = 17'(max_cfg);
    end
    loss_mark = seq - 16'd1;
    hist_head = hist_head + 3'd1;
    hist_ring[hist_head] = ival[4:0];
    if (hist_len < 8) hist_len++;
    losses++;
  endtask

  task automatic refresh_estimate(input logic [15:0] seq);
    logic [15:0] open_len;
    logic [63:0] num_a, den_a, num_b, den_b, num, den, q;
    logic [2:0]  slot;
    int          k;
    open_len = seq - loss_mark;
    num_a = 0;
    den_a = 0;
    for (k = 0; k < hist_len; k++) begin
      slot = hist_head - k[2:0];
      num_a += FIFTHS[3*k +: 3] * hist_ring[slot];
      den_a += FIFTHS[3*k +: 3];
    end
    num = num_a;
    den = den_a;
    if (hist_len > 1) begin
      // open interval takes the newest weight, closed ones shift down by one
      num_b = FIFTHS[2:0] * open_len;
      den_b = FIFTHS[2:0];
      for (k = 0; k + 1 < hist_len; k++) begin
        slot = hist_head - k[2:0];
        num_b += FIFTHS[3*(k+1) +: 3] * hist_ring[slot];
        den_b += FIFTHS[3*(k+1) +: 3];
      end
      if (num_a * den_b < num_b * den_a) begin
        num = num_b;
        den = den_b;
      end
    end
    q = (num * 256 + den / 2) / den;
    held_avg = (q > 64'hFF_FFFF) ? 24'hFF_FFFF : q[23:0];
    if (num == 0) begin
      held_rate = 16'hFFFF;
    end else begin
      q = (den * 65536 + num / 2) / num;
      held_rate = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
    end
  endtask

  task automatic predict_item(input logic c, input logic [15:0] seq, input logic [15:0] last);
    logic [15:0] ahead;
    estimate_t   e;
    if (c == alie_pkg::CMD_RESTART) begin
      hist_len = 0;
      held_rate = '0;
      held_avg = '0;
    end else begin
      ahead = seq - (last + 16'd1);
      if (ahead != 16'd0 && ahead < 16'h8000) record_interval(seq, last);
      if (hist_len > 0) refresh_estimate(seq);
    end
    e.rate = held_rate;
    e.avg = held_avg;
    e.valid = (hist_len > 0);
    expected_q.push_back(e);
  endtask

  task automatic compare_field(input string name, input logic [23:0] exp_v,
                               input logic [23:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    estimate_t exp_e;
    if (rst) begin
      cap_cfg = alie_pkg::FIRST_LOSS_CAP_RST;
      min_cfg = alie_pkg::INTERVAL_MIN_RST;
      max_cfg = alie_pkg::INTERVAL_MAX_RST;
      hist_head = 3'd7;
      hist_len = 0;
      loss_mark = '0;
      held_rate = '0;
      held_avg = '0;
      expected_q.delete();
    end else begin
      // compare before predicting so a stray result never meets a fresh entry
      if (result_valid && !result_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual rate %0d avg %0d valid %0b",
                   $time, loss_rate, avg_interval, estimate_valid);
          errors++;
        end else begin
          exp_e = expected_q.pop_front();
          compare_field("loss_rate", 24'(exp_e.rate), 24'(loss_rate));
          compare_field("avg_interval", exp_e.avg, avg_interval);
          compare_field("estimate_valid", 24'(exp_e.valid), 24'(estimate_valid));
          checked++;
        end
      end
      if (item_valid && !item_stall) predict_item(cmd, seq_number, last_received);
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        case (paddr[alie_pkg::PADDR_W-1:2])
          alie_pkg::REG_FIRST_LOSS_CAP: cap_cfg = pwdata[4:0];
          alie_pkg::REG_INTERVAL_MIN:   min_cfg = pwdata[4:0];
          alie_pkg::REG_INTERVAL_MAX:   max_cfg = pwdata[4:0];
          default: ;
        endcase
      end
    end
    fail_count <= errors;
    outstanding <= expected_q.size();
    checked_count <= checked;
    loss_count <= losses;
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Top of the estimator testbench: clock, reset, APB setup, item stimulus and
// output stall patterns. Depends on alie_pkg, the unit and loss_estimate_checker.

module testbench;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [alie_pkg::PADDR_W-1:0] paddr = '0;
  logic [alie_pkg::PDATA_W-1:0] pwdata = '0;
  logic [alie_pkg::PDATA_W-1:0] prdata;
  logic                         pready;
  logic                         item_valid = 1'b0;
  logic                         item_stall;
  logic                         cmd = alie_pkg::CMD_UPDATE;
  logic [15:0]                  seq_number = '0;
  logic [15:0]                  last_received = '0;
  logic                         result_valid;
  logic                         result_stall = 1'b0;
  logic [15:0]                  loss_rate;
  logic [23:0]                  avg_interval;
  logic                         estimate_valid;

  int          fail_count, outstanding, checked_count, loss_count;
  int          hold_asks = 0;
  int          items_sent = 0;
  int          restarts_sent = 0;
  int          settings = 1;
  int          loss_pct = 25;
  logic [15:0] stream_last = '0;

  always #5 clk = ~clk;

  average_loss_interval_estimator_unit #(
    .HISTORY_DEPTH(8),
    .SEQ_BITS(16)
  ) DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .item_valid(item_valid), .item_stall(item_stall), .cmd(cmd),
    .seq_number(seq_number), .last_received(last_received),
    .result_valid(result_valid), .result_stall(result_stall),
    .loss_rate(loss_rate), .avg_interval(avg_interval), .estimate_valid(estimate_valid)
  );

  loss_estimate_checker estimate_check (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .item_valid(item_valid), .item_stall(item_stall), .cmd(cmd),
    .seq_number(seq_number), .last_received(last_received),
    .result_valid(result_valid), .result_stall(result_stall),
    .loss_rate(loss_rate), .avg_interval(avg_interval), .estimate_valid(estimate_valid),
    .fail_count(fail_count), .outstanding(outstanding),
    .checked_count(checked_count), .loss_count(loss_count)
  );

  // Output side: random stall modes, plus a long hold whenever one is asked for
  initial begin : stall_pattern
    int mode, span, hold_seen, n;
    hold_seen = 0;
    forever begin
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        repeat (400) begin
          @(negedge clk);
          result_stall <= 1'b1;
        end
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(8, 80);
        for (n = 0; n < span; n++) begin
          @(negedge clk);
          case (mode)
            0: result_stall <= 1'b0;
            1: result_stall <= ($urandom_range(0, 99) < 30);
            2: result_stall <= (n % 4 == 3);
            default: result_stall <= ($urandom_range(0, 99) < 75);
          endcase
        end
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("testbench failed");
    $finish;
  end

  task automatic send_item(input logic c, input logic [15:0] s, input logic [15:0] l);
    @(negedge clk);
    item_valid <= 1'b1;
    cmd <= c;
    seq_number <= s;
    last_received <= l;
    do @(posedge clk); while (item_stall);
    items_sent++;
    if (c == alie_pkg::CMD_RESTART) restarts_sent++;
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      item_valid <= 1'b0;
    end
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [4:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {27'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Drop valid and hold off until every expected estimate has been seen
  task automatic wait_drained;
    idle_cycles(1);
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic make_item(output logic c, output logic [15:0] s, output logic [15:0] l);
    int r;
    r = $urandom_range(0, 99);
    c = alie_pkg::CMD_UPDATE;
    if (r < 3) begin
      c = alie_pkg::CMD_RESTART;
      s = 16'($urandom);
      l = 16'($urandom);
    end else if (r < 9) begin
      s = 16'($urandom);
      l = 16'($urandom);
    end else if (r < 13) begin
      // duplicate or reordered packet
      l = stream_last;
      s = stream_last - 16'($urandom_range(0, 6));
    end else begin
      if (r < 15) begin
        case ($urandom_range(0, 3))
          0: stream_last = 16'hFFFF - 16'($urandom_range(0, 40));
          1: stream_last = '0;
          default: stream_last = 16'($urandom);
        endcase
      end
      l = stream_last;
      if ($urandom_range(0, 99) < loss_pct) begin
        if ($urandom_range(0, 15) == 0)
          s = stream_last + 16'd1 + 16'($urandom_range(41, 3000));
        else s = stream_last + 16'd1 + 16'($urandom_range(1, 40));
      end else begin
        s = stream_last + 16'd1;
      end
      stream_last = s;
    end
  endtask

  initial begin : stimulus
    int          phase, i, burst, gap, no_gap_left, waited;
    logic        c;
    logic [15:0] s, l;
    no_gap_left = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at reset register values
    send_item(alie_pkg::CMD_UPDATE,  16'h0000, 16'h0000);
    send_item(alie_pkg::CMD_UPDATE,  16'h0005, 16'h0000);
    send_item(alie_pkg::CMD_UPDATE,  16'h0006, 16'h0005);
    send_item(alie_pkg::CMD_UPDATE,  16'h0014, 16'h000A);
    send_item(alie_pkg::CMD_UPDATE,  16'h00C8, 16'h0096);
    send_item(alie_pkg::CMD_UPDATE,  16'h00D2, 16'h00C7);
    send_item(alie_pkg::CMD_UPDATE,  16'h00D2, 16'h00D2);
    send_item(alie_pkg::CMD_UPDATE,  16'h00C0, 16'h00D2);
    send_item(alie_pkg::CMD_UPDATE,  16'hFFFF, 16'hFFFF);
    send_item(alie_pkg::CMD_UPDATE,  16'h8000, 16'h0000);
    send_item(alie_pkg::CMD_UPDATE,  16'h8001, 16'h0000);
    send_item(alie_pkg::CMD_UPDATE,  16'h0002, 16'hFFF0);
    // loss at sequence one clears the marker, so the next loss counts as first
    send_item(alie_pkg::CMD_UPDATE,  16'h0001, 16'hFFFD);
    send_item(alie_pkg::CMD_UPDATE,  16'h000A, 16'h0008);
    send_item(alie_pkg::CMD_UPDATE,  16'h0001, 16'hFFF0);
    send_item(alie_pkg::CMD_UPDATE,  16'h0064, 16'h005A);
    send_item(alie_pkg::CMD_UPDATE,  16'h0070, 16'h0068);
    send_item(alie_pkg::CMD_UPDATE,  16'h0080, 16'h0075);
    send_item(alie_pkg::CMD_UPDATE,  16'h0090, 16'h0088);
    send_item(alie_pkg::CMD_RESTART, 16'hFFFF, 16'hFFFF);
    send_item(alie_pkg::CMD_UPDATE,  16'h00C2, 16'h00C1);
    send_item(alie_pkg::CMD_UPDATE,  16'h00D0, 16'h00C2);
    send_item(alie_pkg::CMD_RESTART, 16'h0000, 16'h0000);
    send_item(alie_pkg::CMD_UPDATE,  16'hAAAA, 16'h5555);
    send_item(alie_pkg::CMD_UPDATE,  16'h5555, 16'hAAAA);
    wait_drained();

    for (phase = 0; phase < 6; phase++) begin
      if (phase > 0) begin
        case (phase)
          1: begin
            apb_write(alie_pkg::REG_FIRST_LOSS_CAP, 5'd31);
            apb_write(alie_pkg::REG_INTERVAL_MIN, 5'd1);
            apb_write(alie_pkg::REG_INTERVAL_MAX, 5'd31);
          end
          2: begin
            // crossed clamps
            apb_write(alie_pkg::REG_FIRST_LOSS_CAP, 5'd1);
            apb_write(alie_pkg::REG_INTERVAL_MIN, 5'd31);
            apb_write(alie_pkg::REG_INTERVAL_MAX, 5'd1);
          end
          3: begin
            apb_write(alie_pkg::REG_FIRST_LOSS_CAP, 5'd0);
            apb_write(alie_pkg::REG_INTERVAL_MIN, 5'd0);
            apb_write(alie_pkg::REG_INTERVAL_MAX, 5'd0);
          end
          4: begin
            apb_write(alie_pkg::REG_FIRST_LOSS_CAP, 5'($urandom_range(1, 31)));
            apb_write(alie_pkg::REG_INTERVAL_MIN, 5'($urandom_range(1, 31)));
            apb_write(alie_pkg::REG_INTERVAL_MAX, 5'($urandom_range(1, 31)));
          end
          default: begin
            apb_write(alie_pkg::REG_FIRST_LOSS_CAP, alie_pkg::FIRST_LOSS_CAP_RST);
            apb_write(alie_pkg::REG_INTERVAL_MIN, alie_pkg::INTERVAL_MIN_RST);
            apb_write(alie_pkg::REG_INTERVAL_MAX, alie_pkg::INTERVAL_MAX_RST);
          end
        endcase
        settings++;
      end
      loss_pct = $urandom_range(5, 50);
      i = 0;
      while (i < 275) begin
        burst = $urandom_range(1, 24);
        repeat (burst) begin
          make_item(c, s, l);
          send_item(c, s, l);
          i++;
          if (i == 120 && (phase == 1 || phase == 4)) begin
            // stall the output for a long stretch while items keep coming
            hold_asks = hold_asks + 1;
            no_gap_left = 40;
          end
        end
        if (no_gap_left > 0) begin
          no_gap_left -= burst;
          gap = 0;
        end else begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        idle_cycles(gap);
      end
      if (phase < 5) wait_drained();
    end

    idle_cycles(1);
    waited = 0;
    while (outstanding != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (64) @(negedge clk);
    if (outstanding != 0)
      $display("%0t: %0d expected estimates never arrived", $time, outstanding);

    $display("Ran %0d items (%0d restarts) under %0d register settings with two long holds.",
             items_sent, restarts_sent, settings);
    $display("Checked %0d estimates; %0d loss intervals recorded.", checked_count, loss_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
